// ===== design/mtr_pkg.sv =====
// Package for the timestamp rebase and lookup block: payload structs, codes,
// register reset values. No dependencies.
package mtr_pkg;

  localparam int unsigned MapDepthDefault = 2048;

  localparam logic [61:0] MaxDistReset  = 62'd2000000000;
  localparam logic [29:0] VStepReset    = 30'd33333333;
  localparam logic [29:0] AStepReset    = 30'd20000000;

  typedef enum logic [1:0] {
    FUNC_NORM  = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_VIDEO = 2'd0,
    KIND_AUDIO = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_MAX_DIST = 2'd0,
    REG_VSTEP    = 2'd1,
    REG_ASTEP    = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [1:0]         kind;
    logic signed [63:0] in_pts;
    logic signed [63:0] in_dts;
    logic signed [63:0] query_pts;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] out_pts;
    logic signed [63:0] out_dts;
    logic signed [63:0] resolved_pts;
  } out_item_t;

endpackage

// ===== design/mtr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mtr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/mtr_norm.sv =====
// Normalize datapath: rebase, monotonic push and track state registers.
// Depends on mtr_pkg.
module mtr_norm import mtr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic        clear_i,
  input  logic [1:0]  kind_i,
  input  logic [63:0] pts_i,
  input  logic [63:0] dts_i,
  input  logic [29:0] vstep_def_i,
  input  logic [29:0] astep_def_i,
  output logic [63:0] np_o,
  output logic [63:0] nd_o,
  output logic [63:0] src_o,
  output logic        video_o
);
  logic [63:0] vbase_q, abase_q, pvd_q, pap_q, vstep_q, astep_q;
  logic        vset_q, aset_q, pvd_set_q, pap_set_q;
  logic        pa, da, video, pass;
  logic [63:0] refv, base, np0, nd0, np, nd, dur, off;
  logic        vadv, aadv;

  function automatic logic [63:0] rebase(input logic [63:0] v, input logic [63:0] b);
    rebase = (v[63] || ($signed(v) <= $signed(b))) ? 64'd0 : v - b;
  endfunction

  always_comb begin
    pa    = !pts_i[63];
    da    = !dts_i[63];
    video = (kind_i == KIND_VIDEO);
    pass  = !(kind_i == KIND_VIDEO || kind_i == KIND_AUDIO);
    if (video && pa && da) refv = ($signed(pts_i) < $signed(dts_i)) ? pts_i : dts_i;
    else refv = pa ? pts_i : dts_i;
    if (refv[63]) refv = 64'd0;
    if (video) base = vset_q ? vbase_q : refv;
    else       base = aset_q ? abase_q : refv;
    np0 = pa ? rebase(pts_i, base) : rebase(dts_i, base);
    nd0 = da ? rebase(dts_i, base) : np0;
    np = np0;
    nd = nd0;
    vadv = $signed(nd0) > $signed(pvd_q);
    aadv = $signed(np0) > $signed(pap_q);
    dur = 64'd0;
    off = 64'd0;
    if (video) begin
      dur = ($signed(vstep_q) > 0) ? vstep_q : {34'd0, vstep_def_i};
      off = pvd_q + dur - nd0;
      if (pvd_set_q && !vadv) begin
        np = np0 + off;
        nd = nd0 + off;
      end
    end else begin
      dur = ($signed(astep_q) > 0) ? astep_q : {34'd0, astep_def_i};
      if (pap_set_q && !aadv) begin
        np = pap_q + dur;
        if ($signed(nd0) < $signed(np)) nd = np;
      end
    end
    if (pass) begin
      np = pts_i;
      nd = dts_i;
    end
  end

  assign np_o    = np;
  assign nd_o    = nd;
  assign src_o   = pa ? pts_i : (da ? dts_i : np);
  assign video_o = video;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbase_q <= '0; abase_q <= '0; pvd_q <= '0; pap_q <= '0;
      vstep_q <= '0; astep_q <= '0;
      vset_q <= 1'b0; aset_q <= 1'b0; pvd_set_q <= 1'b0; pap_set_q <= 1'b0;
    end else if (clear_i) begin
      vbase_q <= '0; abase_q <= '0; pvd_q <= '0; pap_q <= '0;
      vstep_q <= '0; astep_q <= '0;
      vset_q <= 1'b0; aset_q <= 1'b0; pvd_set_q <= 1'b0; pap_set_q <= 1'b0;
    end else if (go_i && !pass) begin
      if (video) begin
        vbase_q   <= base;
        vset_q    <= 1'b1;
        if (pvd_set_q && vadv) vstep_q <= nd0 - pvd_q;
        pvd_q     <= nd;
        pvd_set_q <= 1'b1;
      end else begin
        abase_q   <= base;
        aset_q    <= 1'b1;
        if (pap_set_q && aadv) astep_q <= np0 - pap_q;
        pap_q     <= np;
        pap_set_q <= 1'b1;
      end
    end
  end
endmodule

// ===== design/media_timestamp_rebase_and_lookup_top.sv =====
// Top level of the timestamp rebase and lookup block: APB registers, control,
// mapping ring memory. Depends on mtr_pkg, mtr_ram and mtr_norm.
// Normalize and clear pass from the input beat through the done state into the
// output register. A query reads the mapping ring one entry a cycle, newest
// first, through the single read port of the ring memory; an exact match ends
// the scan early. One item is worked at a time; the output register frees the
// input side once the result is loaded, and a result still waiting there holds
// the next item in the done state. There is no clearing pass: the fill count
// keeps unwritten entries from being read.
module media_timestamp_rebase_and_lookup_top import mtr_pkg::*; #(
  parameter int unsigned MapDepth = MapDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  localparam int unsigned AW = (MapDepth > 1) ? $clog2(MapDepth) : 1;
  localparam int unsigned CW = $clog2(MapDepth + 1);
  localparam logic [CW-1:0] DepthC = CW'(MapDepth);

  logic [61:0] maxd_q;
  logic [29:0] vdef_q, adef_q;
  state_e      state_q, state_d;
  in_item_t    item_q;
  out_item_t   res_q;
  logic        res_vld_q;
  logic [AW-1:0] head_q, rd_addr_q;
  logic [CW-1:0] count_q, left_q;
  logic          rd_pend_q;
  logic [63:0]   near_gap_q, best_src_q;
  logic          best_any_q;
  logic          done_q;

  logic        accept, go_norm, go_clear, wr;
  logic [63:0] np, nd, src;
  logic        video;
  logic [127:0] rdata;
  logic [63:0] e, q, diff;
  logic [AW-1:0] rd_addr_d;
  logic        ld_res;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[4:3])
      REG_MAX_DIST: prdata = {2'b0, maxd_q};
      REG_VSTEP:    prdata = {34'b0, vdef_q};
      REG_ASTEP:    prdata = {34'b0, adef_q};
      default:      prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxd_q <= MaxDistReset;
      vdef_q <= VStepReset;
      adef_q <= AStepReset;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:3])
        REG_MAX_DIST: maxd_q <= pwdata[61:0];
        REG_VSTEP:    vdef_q <= pwdata[29:0];
        REG_ASTEP:    adef_q <= pwdata[29:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign go_norm    = ld_res && (item_q.func == FUNC_NORM);
  assign go_clear   = ld_res && (item_q.func == FUNC_CLEAR);

  mtr_norm u_norm (
    .clk_i, .rst_ni,
    .go_i(go_norm), .clear_i(go_clear),
    .kind_i(item_q.kind), .pts_i(item_q.in_pts), .dts_i(item_q.in_dts),
    .vstep_def_i(vdef_q), .astep_def_i(adef_q),
    .np_o(np), .nd_o(nd), .src_o(src), .video_o(video)
  );

  assign wr = go_norm && video;

  mtr_ram #(.Width(128), .Depth(MapDepth)) u_ring (
    .clk_i, .we_i(wr), .waddr_i(head_q), .wdata_i({np, src}),
    .raddr_i(rd_addr_q), .rdata_o(rdata)
  );

  assign e = rdata[127:64];
  assign q = item_q.query_pts;
  assign diff = ($signed(e) >= $signed(q)) ? e - q : q - e;

  always_comb begin
    state_d = state_q;
    ld_res  = 1'b0;
    rd_addr_d = rd_addr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.func == FUNC_QUERY) ? ST_SCAN : ST_DONE;
          rd_addr_d = (head_q == '0) ? AW'(MapDepth - 1) : head_q - 1'b1;
        end
      end
      ST_SCAN: begin
        if (!rd_pend_q && (left_q == '0 || done_q)) state_d = ST_DONE;
        if (left_q != '0 && !done_q)
          rd_addr_d = (rd_addr_q == '0) ? AW'(MapDepth - 1) : rd_addr_q - 1'b1;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!res_vld_q || out_ready_i) begin
          ld_res  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_vld_q <= 1'b0;
      head_q <= '0;
      count_q <= '0;
      left_q <= '0;
      rd_pend_q <= 1'b0;
      best_any_q <= 1'b0;
      done_q <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      state_q   <= state_d;
      rd_addr_q <= rd_addr_d;
      if (accept) begin
        left_q     <= count_q;
        rd_pend_q  <= 1'b0;
        best_any_q <= 1'b0;
        done_q     <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        // issue one read per cycle; compare the entry read last cycle
        rd_pend_q <= (left_q != '0) && !done_q;
        if (left_q != '0 && !done_q) left_q <= left_q - 1'b1;
        if (rd_pend_q && !done_q) begin
          if (!best_any_q || diff < near_gap_q) begin
            best_any_q <= 1'b1;
            if (diff == 64'd0) done_q <= 1'b1;
          end
        end
      end
      if (go_clear) begin
        head_q  <= '0;
        count_q <= '0;
      end else if (wr) begin
        head_q <= (head_q == AW'(MapDepth - 1)) ? '0 : head_q + 1'b1;
        if (count_q != DepthC) count_q <= count_q + 1'b1;
      end
      if (ld_res) res_vld_q <= 1'b1;
      else if (out_ready_i) res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (state_q == ST_SCAN && rd_pend_q && !done_q &&
        (!best_any_q || diff < near_gap_q)) begin
      near_gap_q <= diff;
      best_src_q <= rdata[63:0];
    end
    if (ld_res) begin
      res_q.out_pts <= (item_q.func == FUNC_NORM) ? np : 64'd0;
      res_q.out_dts <= (item_q.func == FUNC_NORM) ? nd : 64'd0;
      if (item_q.func == FUNC_QUERY)
        res_q.resolved_pts <= (best_any_q && near_gap_q <= {2'b0, maxd_q})
                              ? best_src_q : q;
      else
        res_q.resolved_pts <= 64'd0;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

  a_ring_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC) else $error("ring count above depth");
  a_write_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |-> state_q == ST_DONE) else $error("ring write outside done state");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o) else $error("accept while busy");
  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && count_q != DepthC) |=> count_q == $past(count_q) + 1'b1)
    else $error("ring count missed a write");
endmodule
